### src/assert_macros.svh
// Assertion macros shared by the tone burst RTL.
// No dependencies; taken in by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TBG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tbg_pkg.sv
// Types, constants and the phase step table of the tone burst generator.
// No dependencies; used by tbg_sine_rom, tone_burst_generator_top and the testbench.
package tbg_pkg;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam int unsigned TEXT_W     = 10;
    localparam int unsigned CNT_W      = 22;
    localparam int unsigned STEP_W     = 30;
    localparam int unsigned VOL_W      = 17;
    localparam int unsigned MAG_W      = 15;
    localparam int unsigned ENV_W      = 8;
    localparam int unsigned ENVK_W     = 16;
    localparam int unsigned PROD_W     = 49;

    localparam int unsigned BASE_HZ     = 440;
    localparam int unsigned HZ_PER_CHAR = 10;
    localparam int unsigned CAP_HZ      = 3000;
    localparam int unsigned FS_HZ       = 16000;

    localparam logic [VOL_W-1:0]  VOL_FULL         = 17'd65536;
    localparam logic [VOL_W-1:0]  VOL_RESET        = 17'd52429;
    localparam logic [CNT_W-1:0]  RAMP_LEN         = 22'd160;
    localparam logic [CNT_W-1:0]  SAMPLES_PER_CHAR = 22'd3200;
    // 30000 / (32767 * 65536 * 160) == 375 / (32767 * 2^17)
    localparam logic [ENVK_W-1:0] ENV_GAIN         = 16'd375;
    localparam int unsigned       OUT_SHIFT        = 17;

    typedef struct packed {
        logic              action;
        logic [TEXT_W-1:0] text_length;
    } t_tbg_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_tbg_out;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_sine_val;

    // phase step for text length k+1; lengths of 256 and up sit at the cap
    typedef logic [STEP_W-1:0] t_step_lut [256];

    function automatic t_step_lut build_step_lut();
        t_step_lut   t;
        logic [63:0] f;
        logic [63:0] s;
        for (int k = 0; k < 256; k++) begin
            f = 64'(BASE_HZ + HZ_PER_CHAR * (k + 1));
            if (f > 64'(CAP_HZ)) begin
                f = 64'(CAP_HZ);
            end
            s = ((f << 32) + 64'(FS_HZ / 2)) / 64'(FS_HZ);
            t[k] = s[STEP_W-1:0];
        end
        return t;
    endfunction

    localparam t_step_lut STEP_LUT = build_step_lut();

endpackage

### src/tbg_sine_rom.sv
// Quarter-wave sine ROM with quadrant folding and registered read.
// Depends on tbg_pkg; table contents are computed at elaboration.
module tbg_sine_rom import tbg_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic [1:0]                          i_quad,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] i_addr,
    output t_sine_val                           o_val
);

    localparam int          AW          = $clog2(SINE_TABLE_DEPTH);
    localparam int          QTR         = SINE_TABLE_DEPTH / 4;
    localparam int          QW          = $clog2(QTR + 1);
    localparam logic [63:0] QTR64       = 64'(QTR);
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef logic [MAG_W-1:0] t_qtab [QTR + 1];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] taylor_div(input logic [63:0] v, input int n);
        logic [63:0] q;
        case (n)
            1:       q = v / 64'd6;
            2:       q = v / 64'd20;
            3:       q = v / 64'd42;
            4:       q = v / 64'd72;
            5:       q = v / 64'd110;
            6:       q = v / 64'd156;
            7:       q = v / 64'd210;
            8:       q = v / 64'd272;
            default: q = v / 64'd342;
        endcase
        return q;
    endfunction

    function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        logic [63:0] v;
        x     = (HALF_PI_Q62 / QTR64) * j + ((HALF_PI_Q62 % QTR64) * j) / QTR64;
        x2    = mul_q62(x, x);
        term  = x;
        plus  = x;
        minus = 64'd0;
        for (int n = 1; n <= 9; n++) begin
            term = taylor_div(mul_q62(term, x2), n);
            if (n[0]) begin
                minus = minus + term;
            end else begin
                plus = plus + term;
            end
        end
        v = (plus > minus) ? plus - minus : 64'd0;
        v = (64'd32767 * (v >> 20) + (64'd1 << 41)) >> 42;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab t;
        for (int j = 0; j <= QTR; j++) begin
            t[j] = quarter_sine(64'(j));
        end
        return t;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    logic [AW-1:0] base;
    logic [AW-1:0] offs;
    logic [QW-1:0] j_idx;
    logic [QW-1:0] rd_idx;

    always_comb begin
        case (i_quad)
            2'd0:    base = '0;
            2'd1:    base = AW'(QTR);
            2'd2:    base = AW'(2 * QTR);
            default: base = AW'(3 * QTR);
        endcase
        offs   = i_addr - base;
        j_idx  = offs[QW-1:0];
        rd_idx = i_quad[0] ? QW'(QTR) - j_idx : j_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_val.neg <= i_quad[1];
            o_val.mag <= QTAB[rd_idx];
        end
    end

endmodule

### src/tone_burst_generator_top.sv
// Top level of the tone burst generator: sequencer, shared multiplier, output register.
// Depends on tbg_pkg, tbg_sine_rom and assert_macros.svh.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_data): action 0 starts a
// burst of 3200*L samples at min(440+10L, 3000) Hz, L = 0 stops any burst;
// action 1 is a sample tick. A transfer happens when valid is high and stall low.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): one sample per
// tick while a burst runs, last set on its final sample. Starts and idle ticks
// give no output.
// Volume is written through i_cfg_wr_en / i_cfg_wr_data, clamped to 65536.
// A start leaves the sequencer idle. A tick runs S_ADDR, S_ROM, S_MUL1, S_MUL2
// and S_DIV: phase-to-address multiply, sine ROM read, two gain multiplies and
// the divide by 32767, with one 32x17 multiplier shared by the three multiply
// steps. The sample is loaded in S_DIV; the input stalls until S_IDLE again.
// The output register holds a sample while the receiver stalls; a following
// tick runs up to its last step and waits there for the register to free up.
// Reset (synchronous, i_rst_n low) clears the burst, sets volume to 52429 and
// empties the output register; the sine ROM needs no clearing.
module tone_burst_generator_top import tbg_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int MAX_TEXT_LENGTH  = 1023
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [VOL_W-1:0]  i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_tbg_in           i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_tbg_out          o_out_data
);

`include "assert_macros.svh"

    localparam int               AW      = $clog2(SINE_TABLE_DEPTH);
    localparam logic [VOL_W-1:0] DEPTH_K = VOL_W'(SINE_TABLE_DEPTH);
    localparam logic [11:0]      MAX_LEN = 12'(MAX_TEXT_LENGTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADDR = 3'd1;
    localparam logic [2:0] S_ROM  = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [VOL_W-1:0]  r_volume;
    logic [31:0]       r_phase;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_index;
    logic [CNT_W-1:0]  r_length;
    logic              r_active;
    logic [ENV_W-1:0]  r_env;
    logic [ENVK_W-1:0] r_envk;
    logic              r_last;
    logic [PROD_W-1:0] r_prod;
    logic              r_out_valid;
    t_tbg_out          r_out_data;

    t_sine_val         sine;
    logic              in_xfer;
    logic              out_free;
    logic              out_load;
    logic [11:0]       len_ext;
    logic [TEXT_W-1:0] len;
    logic [7:0]        lut_idx;
    logic [ENV_W-1:0]  env;
    logic              last;
    logic [31:0]       mul_a;
    logic [VOL_W-1:0]  mul_b;
    logic [29:0]       quot_in;
    logic [14:0]       q0;
    logic [15:0]       rem;
    logic [1:0]        q_adj;
    logic [15:0]       quot;
    logic [15:0]       sample;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = (r_state == S_DIV) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // start decode
    always_comb begin
        len_ext = {2'b00, i_in_data.text_length};
        if (len_ext > MAX_LEN) begin
            len_ext = MAX_LEN;
        end
        len     = len_ext[TEXT_W-1:0];
        lut_idx = (len >= 10'd256) ? 8'd255 : 8'(len - 10'd1);
    end

    // envelope and end-of-burst flag for the current sample
    always_comb begin
        if (r_index < RAMP_LEN) begin
            env = r_index[ENV_W-1:0];
        end else if (r_index + RAMP_LEN > r_length) begin
            env = ENV_W'(r_length - r_index);
        end else begin
            env = ENV_W'(RAMP_LEN);
        end
        last = (r_index + 22'd1 >= r_length);
    end

    // shared multiplier operands
    always_comb begin
        unique case (r_state)
            S_ADDR: begin
                mul_a = r_phase;
                mul_b = DEPTH_K;
            end
            S_MUL1: begin
                mul_a = {17'd0, sine.mag};
                mul_b = r_volume;
            end
            S_MUL2: begin
                mul_a = r_prod[31:0];
                mul_b = {1'b0, r_envk};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divide by 32767 = 2^15 - 1
    always_comb begin
        quot_in = r_prod[OUT_SHIFT +: 30];
        q0      = quot_in[29:15];
        rem     = {1'b0, quot_in[14:0]} + {1'b0, q0};
        if (rem >= 16'd65534) begin
            q_adj = 2'd2;
        end else if (rem >= 16'd32767) begin
            q_adj = 2'd1;
        end else begin
            q_adj = 2'd0;
        end
        quot   = {1'b0, q0} + {14'd0, q_adj};
        sample = sine.neg ? 16'd0 - quot : quot;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_in_data.action == ACT_TICK) && r_active) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR:  n_state = S_ROM;
            S_ROM:   n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_DIV;
            S_DIV: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    tbg_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rd_en (r_state == S_ROM),
        .i_quad  (r_phase[31:30]),
        .i_addr  (r_prod[32 +: AW]),
        .o_val   (sine)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_volume    <= VOL_RESET;
            r_phase     <= '0;
            r_step      <= '0;
            r_index     <= '0;
            r_length    <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_volume <= (i_cfg_wr_data > VOL_FULL) ? VOL_FULL : i_cfg_wr_data;
            end
            if (in_xfer && (i_in_data.action == ACT_START)) begin
                r_phase <= '0;
                r_index <= '0;
                if (len == '0) begin
                    r_active <= 1'b0;
                    r_length <= '0;
                    r_step   <= '0;
                end else begin
                    r_active <= 1'b1;
                    r_length <= CNT_W'(len) * SAMPLES_PER_CHAR;
                    r_step   <= STEP_LUT[lut_idx];
                end
            end
            if (out_load) begin
                r_phase <= r_phase + {2'b00, r_step};
                r_index <= r_index + 22'd1;
                if (r_last) begin
                    r_active <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_env  <= env;
            r_last <= last;
        end
        if (r_state == S_ADDR) begin
            r_envk <= ENVK_W'(r_env) * ENV_GAIN;
        end
        if ((r_state == S_ADDR) || (r_state == S_MUL1) || (r_state == S_MUL2)) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (out_load) begin
            r_out_data.sample <= sample;
            r_out_data.last   <= r_last;
        end
    end

    `TBG_ASSERT_NXT(a_idle_tick, i_clk, i_rst_n, in_xfer && (i_in_data.action == ACT_TICK) && !r_active, r_state == S_IDLE, "tick while idle started work")
    `TBG_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, out_load && r_last, !r_active, "burst still active after last sample")
    `TBG_ASSERT_IMP(a_index_range, i_clk, i_rst_n, r_active, r_index < r_length, "sample index beyond burst length")
    `TBG_ASSERT_IMP(a_sample_range, i_clk, i_rst_n, r_out_valid, (r_out_data.sample <= 16'sd30000) && (r_out_data.sample >= -16'sd30000), "sample out of range")
    `TBG_ASSERT_NXT(a_zero_start, i_clk, i_rst_n, in_xfer && (i_in_data.action == ACT_START) && (len == '0), !r_active && (r_state == S_IDLE), "zero-length start left a burst running")

endmodule

### sim/tb_tone_burst_generator_top.sv
// Self-checking testbench for tone_burst_generator_top: directed and random start/tick traffic.
// A scoreboard class predicts every sample; depends on tbg_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_tone_burst_generator_top;
    import tbg_pkg::*;

    localparam int          SINE_DEPTH      = 1024;
    localparam int          MAX_LEN         = 1023;
    localparam logic [63:0] HALF_PI_Q62     = 64'h6487_ED51_10B4_611A;
    localparam int unsigned RAMP            = 160;
    localparam int          SETTLE_CYCLES   = 12;
    localparam int          WATCHDOG_LIMIT  = 4000;
    localparam int unsigned ITEMS_PER_PHASE = 20;
    localparam int          MAX_PRINTED     = 40;

    class tone_scoreboard;
        int          sine_rom [SINE_DEPTH];
        logic [16:0] volume;
        logic [31:0] phase_acc;
        logic [31:0] phase_step;
        int unsigned sample_idx;
        int unsigned burst_len;
        bit          burst_on;
        t_tbg_out    expected_samples [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned lasts_seen;
        int unsigned transfers;
        int unsigned idle_ticks;

        function new();
            int unsigned q;
            int unsigned quad;
            int unsigned j;
            int          m;
            q = SINE_DEPTH / 4;
            for (int k = 0; k < SINE_DEPTH; k++) begin
                quad = (k / q) & 3;
                j    = k % q;
                m    = (quad & 1) ? quarter_sine(q - j, q) : quarter_sine(j, q);
                sine_rom[k] = (quad & 2) ? -m : m;
            end
            volume     = VOL_RESET;
            phase_acc  = '0;
            phase_step = '0;
            sample_idx = 0;
            burst_len  = 0;
            burst_on   = 1'b0;
        endfunction

        // (a * b) >> 62 on the full product
        function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[125:62];
        endfunction

        // round(32767 * sin(pi/2 * j / q)), Taylor series in Q62
        function int quarter_sine(int unsigned j, int unsigned q);
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] plus;
            logic [63:0] minus;
            logic [63:0] v;
            x = (HALF_PI_Q62 / 64'(q)) * 64'(j) + ((HALF_PI_Q62 % 64'(q)) * 64'(j)) / 64'(q);
            x2    = q62_mul(x, x);
            term  = x;
            plus  = x;
            minus = '0;
            for (int n = 1; n <= 9; n++) begin
                term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    minus += term;
                end else begin
                    plus += term;
                end
            end
            v = (plus > minus) ? plus - minus : 64'd0;
            v = (64'd32767 * (v >> 20) + (64'd1 << 41)) >> 42;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            return int'(v);
        endfunction

        function void set_volume(logic [16:0] v);
            volume = (v > VOL_FULL) ? VOL_FULL : v;
        endfunction

        function void note_transfer(t_tbg_in item);
            int unsigned len;
            int unsigned hz;
            int unsigned env;
            int          rom_val;
            logic [63:0] addr;
            logic [63:0] mag;
            t_tbg_out    res;
            transfers++;
            if (item.action == ACT_START) begin
                len = item.text_length;
                if (len > MAX_LEN) begin
                    len = MAX_LEN;
                end
                phase_acc  = '0;
                sample_idx = 0;
                if (len == 0) begin
                    burst_on   = 1'b0;
                    burst_len  = 0;
                    phase_step = '0;
                end else begin
                    hz = BASE_HZ + HZ_PER_CHAR * len;
                    if (hz > CAP_HZ) begin
                        hz = CAP_HZ;
                    end
                    phase_step = 32'(((64'(hz) << 32) + 64'(FS_HZ / 2)) / 64'(FS_HZ));
                    burst_len  = 3200 * len;
                    burst_on   = 1'b1;
                end
            end else if (!burst_on) begin
                idle_ticks++;
            end else begin
                addr    = (64'(phase_acc) * 64'(SINE_DEPTH)) >> 32;
                rom_val = sine_rom[int'(addr % SINE_DEPTH)];
                if (sample_idx < RAMP) begin
                    env = sample_idx;
                end else if (sample_idx + RAMP > burst_len) begin
                    env = burst_len - sample_idx;
                end else begin
                    env = RAMP;
                end
                mag = 64'((rom_val < 0) ? -rom_val : rom_val);
                mag = mag * 64'(volume) * 64'(env) * 64'd30000;
                mag = mag / (64'd32767 * 64'd65536 * 64'd160);
                res.sample = (rom_val < 0) ? (16'd0 - mag[15:0]) : mag[15:0];
                res.last   = (sample_idx + 1 >= burst_len);
                expected_samples = {expected_samples, res};
                phase_acc += phase_step;
                sample_idx++;
                if (res.last) begin
                    burst_on = 1'b0;
                end
            end
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTED) begin
                $display("[%0t] MISMATCH %s", $realtime, what);
            end
            errors++;
        endtask

        task check_sample(t_tbg_out got);
            t_tbg_out want;
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %0d last %0b", got.sample, got.last));
                return;
            end
            want = expected_samples.pop_front();
            checked++;
            if (want.last) begin
                lasts_seen++;
            end
            if (got.sample !== want.sample) begin
                report_mismatch($sformatf("sample %0d: got %0d, want %0d",
                                          checked, got.sample, want.sample));
            end
            if (got.last !== want.last) begin
                report_mismatch($sformatf("sample %0d: last got %0b, want %0b",
                                          checked, got.last, want.last));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [VOL_W-1:0]   i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_stall;
    t_tbg_in            i_in_data;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_tbg_out           o_out_data;

    bit                 no_gaps = 1'b0;
    int unsigned        volume_settings = 1;
    tone_scoreboard     sb;

    tone_burst_generator_top #(
        .SINE_TABLE_DEPTH (SINE_DEPTH),
        .MAX_TEXT_LENGTH  (MAX_LEN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !no_gaps && ($urandom_range(99) < 26);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_sample(o_out_data);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_item(logic action, logic [TEXT_W-1:0] len);
        t_tbg_in item;
        item.action      = action;
        item.text_length = len;
        while (!no_gaps && $urandom_range(99) < 26) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_transfer(item);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // block must be idle: drain, then let any start or idle tick finish
    task automatic write_volume(logic [VOL_W-1:0] v);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_volume(v);
        volume_settings++;
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned goal;
        int unsigned ticks;
        int unsigned pick;
        int unsigned len;
        goal = sb.transfers - sb.idle_ticks + count;
        while (sb.transfers - sb.idle_ticks < goal) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                if (pick < 50) begin
                    len = $urandom_range(MAX_LEN, 1);
                end else if (pick < 75) begin
                    len = $urandom_range(8, 1);
                end else if (pick < 80) begin
                    len = 0;
                end else begin
                    len = $urandom_range(300, 240);
                end
                send_item(ACT_START, TEXT_W'(len));
                ticks = ($urandom_range(9) == 0) ? $urandom_range(400, 150)
                                                 : $urandom_range(40, 1);
                repeat (ticks) send_item(ACT_TICK, TEXT_W'($urandom));
            end else begin
                repeat ($urandom_range(5, 1)) send_item(1'($urandom), TEXT_W'($urandom));
            end
            if ($urandom_range(24) == 0) begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        logic [VOL_W-1:0] gain_list [4];
        gain_list = '{17'd0, 17'h1FFFF, 17'd65535, 17'd1};
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle tick, zero-length start, short and capped bursts, restarts, stop
        send_item(ACT_TICK, 10'h3FF);
        send_item(ACT_START, 10'd0);
        send_item(ACT_TICK, 10'd0);
        send_item(ACT_START, 10'd1);
        repeat (5) send_item(ACT_TICK, 10'h2AA);
        send_item(ACT_START, 10'd1023);
        repeat (3) send_item(ACT_TICK, 10'h155);
        send_item(ACT_START, 10'd256);
        repeat (2) send_item(ACT_TICK, 10'd0);
        send_item(ACT_START, 10'd255);
        repeat (2) send_item(ACT_TICK, 10'd0);
        send_item(ACT_START, 10'd0);
        send_item(ACT_TICK, 10'd0);
        send_item(ACT_START, 10'd512);
        send_item(ACT_TICK, 10'h3FF);

        random_phase(ITEMS_PER_PHASE);
        foreach (gain_list[g]) begin
            write_volume(gain_list[g]);
            random_phase(ITEMS_PER_PHASE);
        end
        repeat (2) begin
            write_volume(VOL_W'($urandom_range(131071)));
            random_phase(ITEMS_PER_PHASE);
        end

        // one complete burst at full scale, with no input gaps and no output stalls
        write_volume(VOL_FULL);
        no_gaps = 1'b1;
        send_item(ACT_START, 10'd1);
        repeat (3202) send_item(ACT_TICK, TEXT_W'($urandom));
        no_gaps = 1'b0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d input transfers (%0d idle ticks) across %0d volume settings;",
                 sb.transfers, sb.idle_ticks, volume_settings);
        $display("%0d samples checked, %0d burst ends, %0d mismatches",
                 sb.checked, sb.lasts_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### tone_burst_generator_top.f
+incdir+src
src/tbg_pkg.sv
src/tbg_sine_rom.sv
src/tone_burst_generator_top.sv
sim/tb_tone_burst_generator_top.sv
